FILE: rtl/gmrt_pkg.sv
// Package with the types, constants and defaults shared by the region table modules.
package gmrt_pkg;

  localparam int unsigned MaxRegionsDef = 16;
  localparam int unsigned PageBitsDef   = 12;

  localparam logic [1:0] TypeInvalid = 2'd0;
  localparam logic [1:0] TypeMmio    = 2'd1;
  localparam logic [1:0] TypeVmem    = 2'd2;

  localparam logic [3:0] OcUpdated  = 4'd0;
  localparam logic [3:0] OcReused   = 4'd1;
  localparam logic [3:0] OcAppended = 4'd2;
  localparam logic [3:0] OcRefused  = 4'd3;
  localparam logic [3:0] OcFull     = 4'd4;
  localparam logic [3:0] OcNoRegion = 4'd5;
  localparam logic [3:0] OcFbHole   = 4'd6;
  localparam logic [3:0] OcMmio     = 4'd7;
  localparam logic [3:0] OcVmem     = 4'd8;
  localparam logic [3:0] OcBadType  = 4'd9;

  localparam logic [31:0] FbHoleLo = 32'h000A_0000;
  localparam logic [31:0] FbHoleHi = 32'h000C_0000;

  typedef struct packed {
    logic        func;
    logic [31:0] start_req;
    logic [31:0] size;
    logic [1:0]  region_type;
    logic [31:0] fault_addr;
  } in_t;

  typedef struct packed {
    logic [3:0]  outcome;
    logic [31:0] map_addr;
    logic        overlap;
  } out_t;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] size;
    logic [1:0]  rtype;
  } entry_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic decide;
  } sts_t;

endpackage

FILE: rtl/guest_memory_region_table_top.sv
// Top level of the guest memory region table: controller, datapath and ports.
//
// Channel   Direction  Handshake              Payload
// input     in         in_valid_i/in_ready_o  in_data_i (gmrt_pkg::in_t)
// result    out        out_valid_o/out_ready_i out_data_o (gmrt_pkg::out_t)
// config    in         cfg_we_i               cfg_wdata_i (video base)
//
// One transaction passes through acceptance, a scan of the stored entries and a commit. The scan
// stops at the deciding entry or after the last of the current region count; the commit waits
// while the output register is still occupied, and the result is registered at the commit.
// One transaction is handled at a time; the next one is accepted while the last
// result still waits in the output register, but it cannot commit until that is taken.
// Reset clears the region count and the video base; the store itself is not cleared.
module guest_memory_region_table_top #(
  parameter int unsigned MaxRegions = gmrt_pkg::MaxRegionsDef,
  parameter int unsigned PageBits   = gmrt_pkg::PageBitsDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  gmrt_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output gmrt_pkg::out_t out_data_o,
  input  logic           cfg_we_i,
  input  logic [31:0]    cfg_wdata_i
);

  gmrt_pkg::cmd_t cmd;
  gmrt_pkg::sts_t sts;

  gmrt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  gmrt_dp #(
    .MaxRegions (MaxRegions),
    .PageBits   (PageBits)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: rtl/gmrt_ram.sv
// Generic single write port, single read port RAM with registered read data.
module gmrt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: rtl/gmrt_ctrl.sv
// Controller state machine that sequences load, scan, commit and the result handshake.
module gmrt_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output gmrt_pkg::cmd_t cmd_o,
  input  gmrt_pkg::sts_t sts_i
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StScan = 2'd1;
  localparam logic [1:0] StFin  = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign slot_free   = !out_valid_q || out_ready_i;

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StScan;
        end
      end
      StScan: begin
        cmd_o.scan = 1'b1;
        if (sts_i.decide) begin
          state_d = StFin;
        end
      end
      StFin: begin
        if (slot_free) begin
          cmd_o.commit = 1'b1;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_commit_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> (!out_valid_q || out_ready_i))
    else $error("Result committed while the output register was still occupied.");

  a_commit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> (out_valid_o && state_q == StIdle))
    else $error("Committed result not presented on the output.");

  a_scan_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StScan && !sts_i.decide) |=> (state_q == StScan))
    else $error("Scan left before a decision was reached.");

endmodule

FILE: rtl/gmrt_dp.sv
// Datapath with the region store, scan index, decision registers and result register.
module gmrt_dp #(
  parameter int unsigned MaxRegions = gmrt_pkg::MaxRegionsDef,
  parameter int unsigned PageBits   = gmrt_pkg::PageBitsDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  gmrt_pkg::cmd_t cmd_i,
  output gmrt_pkg::sts_t sts_o,
  input  gmrt_pkg::in_t  in_data_i,
  input  logic           cfg_we_i,
  input  logic [31:0]    cfg_wdata_i,
  output gmrt_pkg::out_t out_data_o
);

  localparam int unsigned AddrW = (MaxRegions > 1) ? $clog2(MaxRegions) : 1;
  localparam int unsigned CntW  = $clog2(MaxRegions + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MaxRegions);
  localparam logic [31:0] PageMask = ~((32'd1 << PageBits) - 32'd1);

  gmrt_pkg::in_t    item_q;
  logic [32:0]      end_q;
  logic [CntW-1:0]  idx_q, idx_d;
  logic [CntW-1:0]  count_q;
  logic [31:0]      video_base_q;
  logic             ovl_q;
  logic [3:0]       oc_q, oc_d;
  logic             wr_q, wr_d;
  logic             app_q, app_d;
  logic [AddrW-1:0] widx_q, widx_d;
  logic [31:0]      off_q;
  gmrt_pkg::out_t   out_q;

  gmrt_pkg::entry_t ent, wr_ent;
  logic [$bits(gmrt_pkg::entry_t)-1:0] rdata;

  logic        end_scan, is_fault, match, e_inv, ovl, contain, decide;
  logic [32:0] s33, es33, ee33;
  logic [31:0] diff;

  gmrt_ram #(
    .Width ($bits(gmrt_pkg::entry_t)),
    .Depth (MaxRegions)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.commit && wr_q),
    .waddr_i (widx_q),
    .wdata_i (wr_ent),
    .raddr_i (idx_d[AddrW-1:0]),
    .rdata_o (rdata)
  );

  assign ent             = gmrt_pkg::entry_t'(rdata);
  assign wr_ent.start    = item_q.start_req;
  assign wr_ent.size     = item_q.size;
  assign wr_ent.rtype    = item_q.region_type;

  assign end_scan = (idx_q >= count_q);
  assign is_fault = item_q.func;
  assign match    = (ent.start == item_q.start_req);
  assign e_inv    = (ent.rtype == gmrt_pkg::TypeInvalid);
  assign s33      = {1'b0, item_q.start_req};
  assign es33     = {1'b0, ent.start};
  assign ee33     = es33 + {1'b0, ent.size};
  assign ovl      = (s33 > es33 && s33 < ee33) || (end_q > es33 && end_q < ee33) ||
                    (s33 < es33 && end_q > es33);
  assign diff     = item_q.fault_addr - ent.start;
  assign contain  = (item_q.fault_addr >= ent.start) && (diff < ent.size);
  assign decide   = end_scan || (is_fault ? contain : (match || e_inv));

  assign sts_o.decide = cmd_i.scan && decide;
  assign out_data_o   = out_q;

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.load) begin
      idx_d = '0;
    end else if (cmd_i.scan && !decide) begin
      idx_d = idx_q + CntW'(1);
    end
  end

  always_comb begin
    oc_d   = gmrt_pkg::OcNoRegion;
    wr_d   = 1'b0;
    app_d  = 1'b0;
    widx_d = idx_q[AddrW-1:0];
    if (!is_fault) begin
      if (end_scan) begin
        if (count_q >= CntMax) begin
          oc_d = gmrt_pkg::OcFull;
        end else begin
          oc_d   = gmrt_pkg::OcAppended;
          wr_d   = 1'b1;
          app_d  = 1'b1;
          widx_d = count_q[AddrW-1:0];
        end
      end else if (match) begin
        if (ent.rtype == gmrt_pkg::TypeVmem &&
            item_q.region_type != gmrt_pkg::TypeInvalid) begin
          oc_d = gmrt_pkg::OcRefused;
        end else begin
          oc_d = gmrt_pkg::OcUpdated;
          wr_d = 1'b1;
        end
      end else begin
        oc_d = gmrt_pkg::OcReused;
        wr_d = 1'b1;
      end
    end else begin
      if (end_scan) begin
        oc_d = gmrt_pkg::OcNoRegion;
      end else if (item_q.fault_addr inside
                   {[gmrt_pkg::FbHoleLo : gmrt_pkg::FbHoleHi - 32'd1]}) begin
        oc_d = gmrt_pkg::OcFbHole;
      end else if (ent.rtype == gmrt_pkg::TypeMmio) begin
        oc_d = gmrt_pkg::OcMmio;
      end else if (ent.rtype == gmrt_pkg::TypeVmem) begin
        oc_d = gmrt_pkg::OcVmem;
      end else begin
        oc_d = gmrt_pkg::OcBadType;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q        <= '0;
      count_q      <= '0;
      video_base_q <= '0;
      ovl_q        <= 1'b0;
      wr_q         <= 1'b0;
      app_q        <= 1'b0;
    end else begin
      idx_q <= idx_d;
      if (cfg_we_i) begin
        video_base_q <= cfg_wdata_i;
      end
      if (cmd_i.load) begin
        ovl_q <= 1'b0;
      end else if (cmd_i.scan && !decide && !is_fault && ovl) begin
        ovl_q <= 1'b1;
      end
      if (cmd_i.scan && decide) begin
        wr_q  <= wr_d;
        app_q <= app_d;
      end
      if (cmd_i.commit && app_q) begin
        count_q <= count_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_data_i;
      end_q  <= {1'b0, in_data_i.start_req} + {1'b0, in_data_i.size};
    end
    if (cmd_i.scan && decide) begin
      oc_q   <= oc_d;
      widx_q <= widx_d;
      off_q  <= diff;
    end
    if (cmd_i.commit) begin
      out_q.outcome  <= oc_q;
      out_q.overlap  <= ovl_q;
      out_q.map_addr <= (oc_q == gmrt_pkg::OcVmem) ? ((video_base_q + off_q) & PageMask)
                                                    : '0;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntMax)
    else $error("Region count exceeds the table depth.");

  a_count_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.commit && app_q) |=> $stable(count_q))
    else $error("Region count changed without an append.");

  a_append_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && app_q) |-> (count_q < CntMax))
    else $error("Append committed into a full table.");

endmodule
